>>> rtl/bfm_pkg.sv
// Shared types, constants and helpers for the Bloom filter with MurmurHash3 x86_32.
// No dependencies; the remainder unit and the top level import this package.
package bfm_pkg;

  localparam int MAX_BITS      = 65536;
  localparam int MAX_HASHES    = 16;
  localparam int MAX_KEY_BYTES = 1024;

  localparam int BIT_W   = $clog2(MAX_BITS);          // filter bit index width
  localparam int WORDS   = MAX_BITS / 32;             // 32-bit words in the store
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SIZE_W  = 17;                        // bit_array_size register
  localparam int CNT_W   = 5;                         // hash_count register
  localparam int LANE_W  = $clog2(MAX_HASHES);
  localparam int LEN_W   = $clog2(MAX_KEY_BYTES + 2);
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int REM_W   = BIT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  localparam logic OP_INSERT = 1'b0;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
  localparam logic [31:0] MM_N  = 32'he6546b64;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_KSCR1, S_KSCR2, S_LANE, S_FIN,
    S_FM1, S_FM2, S_FM3, S_DIV, S_RD, S_CHK, S_EMIT
  } state_t;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [31:0]       dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  // answer from the remainder unit
  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

>>> rtl/bfm_if.sv
// Valid/ready channel interfaces for key bytes in and results out.
// No dependencies; the interfaces use only plain bits.
interface bfm_key_if;
  logic valid;
  logic ready;
  logic op;
  logic [7:0] key_byte;
  logic last_byte;
  modport source (output valid, op, key_byte, last_byte, input ready);
  modport sink   (input valid, op, key_byte, last_byte, output ready);
endinterface

interface bfm_res_if;
  logic valid;
  logic ready;
  logic was_lookup;
  logic present;
  logic too_long;
  modport source (output valid, was_lookup, present, too_long, input ready);
  modport sink   (input valid, was_lookup, present, too_long, output ready);
endinterface

>>> rtl/bfm_mod.sv
// Iterative remainder unit: 32-bit digest modulo the filter size, one bit per cycle.
// Depends on bfm_pkg for the request/answer structs.
module bfm_mod (
  input  logic                  clk,
  input  logic                  rst,
  input  bfm_pkg::div_req_t     req,
  output bfm_pkg::div_rsp_t     rsp
);
  import bfm_pkg::*;

  logic [31:0]      dq;
  logic [REM_W-1:0] rem;
  logic [5:0]       cnt;
  logic             busy;
  logic [REM_W:0]   trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, dq[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
    end else if (busy && cnt != '0) begin
      dq <= {dq[30:0], 1'b0};
      if (trial >= {1'b0, req.divisor}) rem <= REM_W'(trial - {1'b0, req.divisor});
      else rem <= trial[REM_W-1:0];
    end
  end

  assign rsp.done = busy && (cnt == '0);
  assign rsp.rem  = rem;
endmodule

>>> rtl/bloom_filter_murmur3.sv
// Bloom filter keyed by byte strings, hashed with MurmurHash3 x86_32 (seeds 0 up).
// One key byte is taken per request; a byte that completes a 4-byte block goes
// through the key scramble multiplies and then mixes every hash lane (16 lanes),
// one after another, while other bytes are only collected. The last byte then
// finalizes each configured hash lane through the shared multiplier and a bit-serial
// remainder unit (fmix, modulo, store read and update), after any tail bytes are
// scrambled, and the result is handed out last. After reset the 2048-word bit store
// is cleared, during which no key byte is taken. Depends on bfm_pkg, bfm_if, bfm_mod.
module bloom_filter_murmur3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bfm_pkg::CFG_W-1:0]     cfg_data,
  bfm_key_if.sink                       key_in,
  bfm_res_if.source                     res_out
);
  import bfm_pkg::*;

  state_t state, state_next;

  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  count_reg;
  logic [31:0]       lanes [MAX_HASHES];
  logic [31:0]       pend;
  logic [31:0]       kreg;
  logic [31:0]       hreg;
  logic [LEN_W-1:0]  klen;
  logic [LANE_W-1:0] lane;
  logic              blk, last_r, op_r, all_set;
  logic [WADDR_W-1:0] clr_addr;
  logic [31:0]       fmem [WORDS];
  logic [31:0]       rdata;
  logic              mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [BIT_W-1:0]  idx;
  logic              out_valid, out_lookup, out_present, out_long;

  // accept-side values
  logic              accept, too_long, klen_under;
  logic [LEN_W-1:0]  klen_new;
  logic [31:0]       pend_base, pend_new;
  logic              blk_new;

  // effective config
  logic [SIZE_W-1:0] size_eff;
  logic [CNT_W-1:0]  count_eff;
  logic              lane_end;

  // shared multiplier
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] lane_eff_mix, lane_eff_fin, mix_x, fin_x;

  div_req_t dreq;
  div_rsp_t drsp;

  bfm_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign accept     = key_in.valid && key_in.ready;
  assign key_in.ready = (state == S_IDLE);
  assign too_long   = (klen > LEN_W'(MAX_KEY_BYTES));
  assign klen_under = (klen < LEN_W'(MAX_KEY_BYTES));
  assign pend_base  = (klen == '0) ? 32'd0 : pend;
  assign pend_new   = pend_base | (32'(key_in.key_byte) << {klen[1:0], 3'b000});
  assign klen_new   = klen_under ? klen + LEN_W'(1) : LEN_W'(MAX_KEY_BYTES + 1);
  assign blk_new    = klen_under && (klen_new[1:0] == 2'b00);

  always_comb begin
    size_eff = size_reg;
    if (size_reg == '0) size_eff = SIZE_W'(1);
    else if (size_reg > SIZE_W'(MAX_BITS)) size_eff = SIZE_W'(MAX_BITS);
    count_eff = (count_reg > CNT_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : count_reg;
  end
  assign lane_end = (CNT_W'(lane) + CNT_W'(1) >= count_eff);

  // lane value, or the seed while no block has been mixed yet
  assign lane_eff_mix = (klen < LEN_W'(8)) ? 32'(lane) : lanes[lane];
  assign lane_eff_fin = (klen < LEN_W'(4)) ? 32'(lane) : lanes[lane];
  assign mix_x = rotl32(lane_eff_mix ^ kreg, 13);
  assign fin_x = lane_eff_fin ^ ((klen[1:0] != 2'b00) ? kreg : 32'd0) ^ 32'(klen);

  // multiplier operand select
  always_comb begin
    mul_a = hreg;
    mul_b = MM_F1;
    case (state)
      S_KSCR1: begin mul_a = kreg; mul_b = MM_C1; end
      S_KSCR2: begin mul_a = rotl32(hreg, 15); mul_b = MM_C2; end
      S_FM1:   begin mul_a = hreg; mul_b = MM_F1; end
      S_FM2:   begin mul_a = hreg ^ (hreg >> 13); mul_b = MM_F2; end
      default: begin mul_a = hreg; mul_b = MM_F1; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign dreq.start    = (state == S_FM3);
  assign dreq.dividend = hreg ^ (hreg >> 16);
  assign dreq.divisor  = size_eff;
  assign idx = drsp.rem[BIT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == WADDR_W'(WORDS - 1)) state_next = S_IDLE;
      S_IDLE: if (accept) begin
        if (blk_new) state_next = S_KSCR1;
        else if (key_in.last_byte) begin
          if (klen_new > LEN_W'(MAX_KEY_BYTES) || count_eff == '0) state_next = S_EMIT;
          else state_next = S_KSCR1;
        end
      end
      S_KSCR1: state_next = S_KSCR2;
      S_KSCR2: state_next = blk ? S_LANE : S_FIN;
      S_LANE: if (lane == LANE_W'(MAX_HASHES - 1)) begin
        if (!last_r) state_next = S_IDLE;
        else if (count_eff == '0) state_next = S_EMIT;
        else state_next = S_FIN;
      end
      S_FIN:  state_next = S_FM1;
      S_FM1:  state_next = S_FM2;
      S_FM2:  state_next = S_FM3;
      S_FM3:  state_next = S_DIV;
      S_DIV:  if (drsp.done) state_next = S_RD;
      S_RD:   state_next = S_CHK;
      S_CHK:  state_next = lane_end ? S_EMIT : S_FIN;
      S_EMIT: if (!out_valid || res_out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg  <= SIZE_W'(65536);
      count_reg <= CNT_W'(7);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
        REG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // key state and lane loop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      klen     <= '0;
      lane     <= '0;
      clr_addr <= '0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + WADDR_W'(1);
      if (accept) begin
        klen <= klen_new;
        lane <= '0;
      end
      if (state == S_LANE && lane == LANE_W'(MAX_HASHES - 1)) lane <= '0;
      else if (state == S_LANE || state == S_CHK) lane <= lane + LANE_W'(1);
      if (state == S_EMIT && state_next == S_IDLE) klen <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kreg    <= pend_new;
      pend    <= (blk_new || key_in.last_byte) ? 32'd0 : pend_new;
      blk     <= blk_new;
      last_r  <= key_in.last_byte;
      op_r    <= key_in.op;
      all_set <= 1'b1;
    end
    case (state)
      S_KSCR1: hreg <= prod;
      S_KSCR2: kreg <= prod;
      S_LANE:  lanes[lane] <= mix_x + (mix_x << 2) + MM_N;
      S_FIN:   hreg <= fin_x ^ (fin_x >> 16);
      S_FM1:   hreg <= prod;
      S_FM2:   hreg <= prod;
      S_CHK:   if (op_r != OP_INSERT && !rdata[idx[4:0]]) all_set <= 1'b0;
      default: ;
    endcase
  end

  // bit store: clearing sweep, then a read of one word per probe, written back with the bit set on insert
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[BIT_W-1:5];
    mem_wdata = rdata | (32'd1 << idx[4:0]);
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 32'd0;
    end else if (state == S_CHK && op_r == OP_INSERT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) fmem[mem_waddr] <= mem_wdata;
    rdata <= fmem[idx[BIT_W-1:5]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || res_out.ready)) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || res_out.ready)) begin
      out_lookup  <= op_r;
      out_long    <= too_long;
      out_present <= too_long ? 1'b0 : ((op_r == OP_INSERT) ? 1'b1 : all_set);
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.was_lookup = out_lookup;
  assign res_out.present    = out_present;
  assign res_out.too_long   = out_long;
endmodule

>>> rtl/bfm_chk.sv
// Port-level checker for the Bloom filter top level, attached by bind.
// Depends on bfm_if signal names through the bind connections.
module bfm_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_present,
  input logic out_long
);
  // the bit store sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during store clear");

  // a finished key closes the input once it is taken, until its result is offered
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("request taken while a key is finishing");

  // an overlong key never reports presence
  a_long_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_long) |-> !out_present)
    else $error("too long key reported present");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
endmodule

bind bloom_filter_murmur3 bfm_chk u_chk (
  .clk(clk), .rst(rst),
  .in_valid(key_in.valid), .in_ready(key_in.ready), .in_last(key_in.last_byte),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .out_present(res_out.present), .out_long(res_out.too_long)
);
